### src/spmv_row_accumulator_with_transfer_cost_top_macros.svh
// Assertion macros for the sparse matrix-vector row accumulator.
`ifndef SPMV_ROW_ACCUMULATOR_WITH_TRANSFER_COST_TOP_MACROS_SVH
`define SPMV_ROW_ACCUMULATOR_WITH_TRANSFER_COST_TOP_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define SPMV_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("spmv: invariant violated");

// Checks that a condition holds in the cycle after its trigger.
`define SPMV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("spmv: sequence violated");

`endif

### src/spmv_pkg.sv
// Shared constants and types of the sparse matrix-vector row accumulator.
package spmv_pkg;

  localparam int unsigned X_DEPTH_DEFAULT = 1024;
  localparam int unsigned MAX_SUBARRAYS   = 64;

  localparam int unsigned KIND_W     = 2;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned NUM_SUB_W  = 7;
  localparam int unsigned LAT_W      = 4;
  localparam int unsigned ROW_W      = 16;
  localparam int unsigned SUM_W      = 48;
  localparam int unsigned CYC_W      = 48;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned PROD_W     = 2 * VAL_W;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = NUM_SUB_W;
  localparam int unsigned Q_DEPTH    = 2;
  localparam int unsigned DIGITS     = IDX_W / 2;
  localparam int unsigned PSUM_EVERY = 4;

  localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NONZERO = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END_ROW = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SUB   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COPY_LAT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_LAT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_LAT = 2'd3;

  localparam logic [SUM_W-1:0] SUM_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [SUM_W-1:0] SUM_MIN = 48'h8000_0000_0000;

  typedef struct packed {
    logic [NUM_SUB_W-1:0] n_eff;
    logic [LAT_W-1:0]     copy_lat;
    logic [LAT_W-1:0]     read_lat;
    logic [LAT_W-1:0]     write_lat;
  } cfg_t;

endpackage

### src/spmv_row_accumulator_with_transfer_cost_top.sv
// An end-of-row word passes the front end, queue and back-end pipeline before
// its result shows. A new word is taken once the last one's index, reduced five
// digits per cycle, is pushed into the queue; a full queue holds it back.
// Reset clears all control state, counters and the row sum, and sets every
// configuration register to 1. The x store is not cleared: no clearing pass,
// each entry holds garbage until written.
`include "spmv_row_accumulator_with_transfer_cost_top_macros.svh"

module spmv_row_accumulator_with_transfer_cost_top #(
  parameter int unsigned X_DEPTH = spmv_pkg::X_DEPTH_DEFAULT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [spmv_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [spmv_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [spmv_pkg::KIND_W-1:0]          kind_i,
  input  logic [spmv_pkg::IDX_W-1:0]           index_i,
  input  logic signed [spmv_pkg::VAL_W-1:0]    value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [spmv_pkg::ROW_W-1:0]           row_number_o,
  output logic signed [spmv_pkg::SUM_W-1:0]    row_sum_o,
  output logic [spmv_pkg::CYC_W-1:0]           cycle_count_o,
  output logic [spmv_pkg::CNT_W-1:0]           transfer_count_o,
  output logic [spmv_pkg::CNT_W-1:0]           psum_xfer_count_o
);

  localparam int unsigned AW = $clog2(X_DEPTH);
  localparam int unsigned NW = spmv_pkg::NUM_SUB_W;
  localparam int unsigned LW = spmv_pkg::LAT_W;
  localparam int unsigned QW = spmv_pkg::KIND_W + AW + NW + spmv_pkg::VAL_W;

  logic [NW-1:0] num_sub_q;
  logic [LW-1:0] copy_lat_q;
  logic [LW-1:0] read_lat_q;
  logic [LW-1:0] write_lat_q;
  spmv_pkg::cfg_t cfg;

  logic                         q_push;
  logic                         q_ready;
  logic                         q_valid;
  logic                         q_pop;
  logic [QW-1:0]                q_wdata;
  logic [QW-1:0]                q_rdata;
  logic [spmv_pkg::KIND_W-1:0]  f_kind;
  logic [AW-1:0]                f_addr;
  logic [NW-1:0]                f_sub;
  logic [spmv_pkg::VAL_W-1:0]   f_value;
  logic [spmv_pkg::KIND_W-1:0]  b_kind;
  logic [AW-1:0]                b_addr;
  logic [NW-1:0]                b_sub;
  logic [spmv_pkg::VAL_W-1:0]   b_value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_sub_q   <= NW'(1);
      copy_lat_q  <= LW'(1);
      read_lat_q  <= LW'(1);
      write_lat_q <= LW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        spmv_pkg::CFG_NUM_SUB:   num_sub_q   <= cfg_data_i;
        spmv_pkg::CFG_COPY_LAT:  copy_lat_q  <= cfg_data_i[LW-1:0];
        spmv_pkg::CFG_READ_LAT:  read_lat_q  <= cfg_data_i[LW-1:0];
        spmv_pkg::CFG_WRITE_LAT: write_lat_q <= cfg_data_i[LW-1:0];
      endcase
    end
  end

  always_comb begin
    priority if (num_sub_q == '0) begin
      cfg.n_eff = NW'(1);
    end else if (int'(num_sub_q) > int'(spmv_pkg::MAX_SUBARRAYS)) begin
      cfg.n_eff = NW'(spmv_pkg::MAX_SUBARRAYS);
    end else begin
      cfg.n_eff = num_sub_q;
    end
    cfg.copy_lat  = copy_lat_q;
    cfg.read_lat  = read_lat_q;
    cfg.write_lat = write_lat_q;
  end

  spmv_front #(
    .X_DEPTH (X_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .index_i    (index_i),
    .value_i    (value_i),
    .n_eff_i    (cfg.n_eff),
    .q_ready_i  (q_ready),
    .q_push_o   (q_push),
    .q_kind_o   (f_kind),
    .q_addr_o   (f_addr),
    .q_sub_o    (f_sub),
    .q_value_o  (f_value)
  );

  assign q_wdata = {f_kind, f_addr, f_sub, f_value};

  spmv_queue #(
    .WIDTH (QW),
    .DEPTH (spmv_pkg::Q_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .data_o  (q_rdata),
    .pop_i   (q_pop)
  );

  assign {b_kind, b_addr, b_sub, b_value} = q_rdata;

  spmv_back #(
    .X_DEPTH (X_DEPTH)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .in_valid_i        (q_valid),
    .in_pop_o          (q_pop),
    .kind_i            (b_kind),
    .addr_i            (b_addr),
    .sub_i             (b_sub),
    .value_i           (b_value),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .row_number_o      (row_number_o),
    .row_sum_o         (row_sum_o),
    .cycle_count_o     (cycle_count_o),
    .transfer_count_o  (transfer_count_o),
    .psum_xfer_count_o (psum_xfer_count_o)
  );

  `SPMV_ASSERT(a_queue_no_overflow, !q_push || q_ready)
  `SPMV_ASSERT(a_queue_pop_valid, !q_pop || q_valid)
  `SPMV_ASSERT_NEXT(a_front_two_steps, in_valid_i && !in_stall_o, in_stall_o)

endmodule

### src/spmv_ram.sv
// Generic single-port RAM with registered read data.
module spmv_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/spmv_queue.sv
// Small FIFO that decouples the classifying front from the executing back.
module spmv_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             ready_o,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o,
  input  logic             pop_i
);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] ptr);
    logic [PW-1:0] res;
    res = (ptr == PW'(DEPTH - 1)) ? '0 : ptr + PW'(1);
    return res;
  endfunction

  assign ready_o = (count_q != CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? next_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### src/spmv_front.sv
// Front end: accepts input words and reduces the index to its address and subarray.
module spmv_front #(
  parameter int unsigned X_DEPTH = spmv_pkg::X_DEPTH_DEFAULT,
  localparam int unsigned AW = $clog2(X_DEPTH)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [spmv_pkg::KIND_W-1:0]          kind_i,
  input  logic [spmv_pkg::IDX_W-1:0]           index_i,
  input  logic signed [spmv_pkg::VAL_W-1:0]    value_i,
  input  logic [spmv_pkg::NUM_SUB_W-1:0]       n_eff_i,
  input  logic                                 q_ready_i,
  output logic                                 q_push_o,
  output logic [spmv_pkg::KIND_W-1:0]          q_kind_o,
  output logic [AW-1:0]                        q_addr_o,
  output logic [spmv_pkg::NUM_SUB_W-1:0]       q_sub_o,
  output logic [spmv_pkg::VAL_W-1:0]           q_value_o
);

  localparam int unsigned RW = AW + 1;
  localparam int unsigned NW = spmv_pkg::NUM_SUB_W;
  localparam int unsigned DG = spmv_pkg::DIGITS;

  typedef enum logic [2:0] {
    FS_IDLE = 3'b001,
    FS_HIGH = 3'b010,
    FS_LOW  = 3'b100
  } front_state_e;

  front_state_e state_q, state_d;

  logic [spmv_pkg::KIND_W-1:0] kind_q;
  logic [spmv_pkg::IDX_W-1:0]  idx_q;
  logic [spmv_pkg::VAL_W-1:0]  value_q;
  logic [NW-1:0]               rn_q, rn_d;
  logic [AW-1:0]               rd_q, rd_d;
  logic [DG-1:0]               digits;
  logic                        done;
  logic                        accept;

  // Restoring remainder, one index digit per step, for both moduli at once.
  always_comb begin
    logic [NW:0] rn_t;
    logic [RW-1:0] rd_t;
    digits = (state_q == FS_LOW) ? idx_q[DG-1:0] : idx_q[spmv_pkg::IDX_W-1:DG];
    rn_d = rn_q;
    rd_d = rd_q;
    for (int i = DG - 1; i >= 0; i--) begin
      rn_t = {rn_d, digits[i]};
      if (rn_t >= {1'b0, n_eff_i}) begin
        rn_t = rn_t - {1'b0, n_eff_i};
      end
      rn_d = rn_t[NW-1:0];
      rd_t = {rd_d, digits[i]};
      if (rd_t >= RW'(X_DEPTH)) begin
        rd_t = rd_t - RW'(X_DEPTH);
      end
      rd_d = rd_t[AW-1:0];
    end
  end

  always_comb begin
    done       = 1'b0;
    in_stall_o = 1'b1;
    unique case (state_q)
      FS_IDLE: begin
        in_stall_o = 1'b0;
      end
      FS_HIGH: begin
        in_stall_o = 1'b1;
      end
      FS_LOW: begin
        done       = q_ready_i;
        in_stall_o = !q_ready_i;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
    accept = in_valid_i && !in_stall_o;
    if (accept) begin
      state_d = FS_HIGH;
    end else if (state_q == FS_HIGH) begin
      state_d = FS_LOW;
    end else if (done || (state_q != FS_LOW)) begin
      state_d = FS_IDLE;
    end else begin
      state_d = state_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= kind_i;
      idx_q   <= index_i;
      value_q <= value_i;
      rn_q    <= '0;
      rd_q    <= '0;
    end else if (state_q == FS_HIGH) begin
      rn_q <= rn_d;
      rd_q <= rd_d;
    end
  end

  assign q_push_o  = done;
  assign q_kind_o  = kind_q;
  assign q_addr_o  = rd_d;
  assign q_sub_o   = rn_d;
  assign q_value_o = value_q;

endmodule

### src/spmv_back.sv
// Back end: x store, multiply-accumulate pipeline, cost counters and result register.
module spmv_back #(
  parameter int unsigned X_DEPTH = spmv_pkg::X_DEPTH_DEFAULT,
  localparam int unsigned AW = $clog2(X_DEPTH)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  spmv_pkg::cfg_t                       cfg_i,
  input  logic                                 in_valid_i,
  output logic                                 in_pop_o,
  input  logic [spmv_pkg::KIND_W-1:0]          kind_i,
  input  logic [AW-1:0]                        addr_i,
  input  logic [spmv_pkg::NUM_SUB_W-1:0]       sub_i,
  input  logic [spmv_pkg::VAL_W-1:0]           value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [spmv_pkg::ROW_W-1:0]           row_number_o,
  output logic signed [spmv_pkg::SUM_W-1:0]    row_sum_o,
  output logic [spmv_pkg::CYC_W-1:0]           cycle_count_o,
  output logic [spmv_pkg::CNT_W-1:0]           transfer_count_o,
  output logic [spmv_pkg::CNT_W-1:0]           psum_xfer_count_o
);

  localparam int unsigned NW = spmv_pkg::NUM_SUB_W;
  localparam int unsigned LW = spmv_pkg::LAT_W;
  localparam int unsigned SW = spmv_pkg::SUM_W;
  localparam int unsigned CY = spmv_pkg::CYC_W;
  localparam int unsigned CN = spmv_pkg::CNT_W;
  localparam int unsigned RW = spmv_pkg::ROW_W;

  logic                         advance;
  logic                         pop;
  logic [spmv_pkg::VAL_W-1:0]   ram_rdata;

  logic                         b_valid_q;
  logic [spmv_pkg::KIND_W-1:0]  b_kind_q;
  logic [NW-1:0]                b_sub_q;
  logic signed [spmv_pkg::VAL_W-1:0] b_value_q;

  logic                         c_valid_q;
  logic [spmv_pkg::KIND_W-1:0]  c_kind_q;
  logic [NW-1:0]                c_sub_q;
  logic signed [spmv_pkg::PROD_W-1:0] prod_q;

  logic signed [SW-1:0]         acc_q;
  logic [RW-1:0]                row_q;
  logic [NW-1:0]                rsub_q;
  logic                         nz_q;
  logic [CY-1:0]                cyc_q;
  logic [CN-1:0]                xfer_q;
  logic [CN-1:0]                psum_q;
  logic                         out_valid_q;

  logic [NW-1:0]                rs;
  logic [NW-1:0]                rs_next;
  logic                         is_nz;
  logic                         is_eor;
  logic                         mismatch;
  logic                         partial;
  logic [LW:0]                  cyc_add;
  logic [CY:0]                  cyc_sum;
  logic [CY-1:0]                cyc_new;
  logic [CN-1:0]                xfer_new;
  logic [CN-1:0]                psum_new;
  logic [SW-1:0]                prod_scaled;
  logic [SW:0]                  acc_sum;
  logic [SW-1:0]                acc_sat;
  logic                         commit;

  assign advance  = !(out_valid_q && out_stall_i);
  assign pop      = in_valid_i && advance;
  assign in_pop_o = pop;

  spmv_ram #(
    .WIDTH (spmv_pkg::VAL_W),
    .DEPTH (X_DEPTH)
  ) u_x_store (
    .clk_i   (clk_i),
    .we_i    (pop && (kind_i == spmv_pkg::KIND_LOAD)),
    .re_i    (pop && (kind_i == spmv_pkg::KIND_NONZERO)),
    .addr_i  (addr_i),
    .wdata_i (value_i),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    rs       = (rsub_q >= cfg_i.n_eff) ? '0 : rsub_q;
    rs_next  = (({1'b0, rs} + (NW + 1)'(1)) >= {1'b0, cfg_i.n_eff}) ? '0 : rs + NW'(1);
    is_nz    = (c_kind_q == spmv_pkg::KIND_NONZERO);
    is_eor   = (c_kind_q == spmv_pkg::KIND_END_ROW);
    mismatch = (c_sub_q != rs);
    partial  = is_eor && nz_q && (cfg_i.n_eff > NW'(1)) &&
               ((row_q & RW'(spmv_pkg::PSUM_EVERY - 1)) == '0);
    if (is_nz) begin
      cyc_add = (mismatch ? {1'b0, cfg_i.copy_lat} : {1'b0, cfg_i.read_lat}) + (LW + 1)'(1);
    end else if (is_eor) begin
      cyc_add = {1'b0, cfg_i.write_lat} + (partial ? {1'b0, cfg_i.copy_lat} : '0);
    end else begin
      cyc_add = '0;
    end
    cyc_sum  = {1'b0, cyc_q} + (CY + 1)'(cyc_add);
    cyc_new  = cyc_sum[CY] ? '1 : cyc_sum[CY-1:0];
    xfer_new = (((is_nz && mismatch) || partial) && (xfer_q != '1)) ? xfer_q + CN'(1) : xfer_q;
    psum_new = (partial && (psum_q != '1)) ? psum_q + CN'(1) : psum_q;

    prod_scaled = prod_q[spmv_pkg::PROD_W-1:spmv_pkg::FRAC_W];
    acc_sum     = {acc_q[SW-1], acc_q} + {prod_scaled[SW-1], prod_scaled};
    if (acc_sum[SW] != acc_sum[SW-1]) begin
      acc_sat = acc_sum[SW] ? spmv_pkg::SUM_MIN : spmv_pkg::SUM_MAX;
    end else begin
      acc_sat = acc_sum[SW-1:0];
    end
    commit = advance && c_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      row_q       <= '0;
      rsub_q      <= '0;
      nz_q        <= 1'b0;
      cyc_q       <= '0;
      xfer_q      <= '0;
      psum_q      <= '0;
    end else begin
      if (advance) begin
        b_valid_q   <= pop;
        c_valid_q   <= b_valid_q;
        out_valid_q <= c_valid_q && is_eor;
      end
      if (commit) begin
        cyc_q  <= cyc_new;
        xfer_q <= xfer_new;
        psum_q <= psum_new;
        rsub_q <= is_eor ? rs_next : rs;
        if (is_nz) begin
          acc_q <= acc_sat;
          nz_q  <= 1'b1;
        end
        if (is_eor) begin
          acc_q <= '0;
          nz_q  <= 1'b0;
          row_q <= row_q + RW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      b_kind_q  <= kind_i;
      b_sub_q   <= sub_i;
      b_value_q <= value_i;
    end
    if (advance && b_valid_q) begin
      c_kind_q <= b_kind_q;
      c_sub_q  <= b_sub_q;
      prod_q   <= b_value_q * $signed(ram_rdata);
    end
    if (commit && is_eor) begin
      row_number_o      <= row_q;
      row_sum_o         <= acc_q;
      cycle_count_o     <= cyc_new;
      transfer_count_o  <= xfer_new;
      psum_xfer_count_o <= psum_new;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### tb/sv/tb_spmv_row_accumulator_with_transfer_cost_top.sv
// Self-checking testbench for the sparse matrix-vector row accumulator and its cost counters.
module tb_spmv_row_accumulator_with_transfer_cost_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [spmv_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned XD = spmv_pkg::X_DEPTH_DEFAULT;
  localparam int unsigned CFG_SETTLE = 12;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned RANDOM_WORDS = 1340;
  localparam int unsigned NUM_PHASES = 9;
  localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_LO = -SUM_HI - 1;

  typedef struct packed {
    logic [spmv_pkg::ROW_W-1:0]        row_number;
    logic signed [spmv_pkg::SUM_W-1:0] row_sum;
    logic [spmv_pkg::CYC_W-1:0]        cycle_count;
    logic [spmv_pkg::CNT_W-1:0]        transfer_count;
    logic [spmv_pkg::CNT_W-1:0]        psum_xfer_count;
  } row_result_t;

  typedef struct packed {
    logic [spmv_pkg::KIND_W-1:0] kind;
    logic [spmv_pkg::IDX_W-1:0]  index;
    logic [spmv_pkg::VAL_W-1:0]  value;
    logic                        sum_known;
    logic [spmv_pkg::SUM_W-1:0]  sum;
  } directed_word_t;

  localparam directed_word_t DIRECTED [20] = '{
    '{spmv_pkg::KIND_END_ROW, 10'd0,    32'h0000_0000, 1'b1, 48'h0},
    '{spmv_pkg::KIND_LOAD,    10'd0,    32'h8000_0000, 1'b0, 48'h0},
    '{spmv_pkg::KIND_LOAD,    10'd1023, 32'h7FFF_FFFF, 1'b0, 48'h0},
    '{spmv_pkg::KIND_LOAD,    10'd1,    32'h0001_0000, 1'b0, 48'h0},
    '{KIND_UNUSED,            10'd1023, 32'hFFFF_FFFF, 1'b0, 48'h0},
    '{spmv_pkg::KIND_NONZERO, 10'd0,    32'h8000_0000, 1'b0, 48'h0},
    '{spmv_pkg::KIND_NONZERO, 10'd0,    32'h8000_0000, 1'b0, 48'h0},
    '{spmv_pkg::KIND_NONZERO, 10'd0,    32'h8000_0000, 1'b0, 48'h0},
    '{spmv_pkg::KIND_END_ROW, 10'd0,    32'h0000_0000, 1'b1, spmv_pkg::SUM_MAX},
    '{spmv_pkg::KIND_NONZERO, 10'd1023, 32'h8000_0000, 1'b0, 48'h0},
    '{spmv_pkg::KIND_NONZERO, 10'd1023, 32'h8000_0000, 1'b0, 48'h0},
    '{spmv_pkg::KIND_NONZERO, 10'd1023, 32'h8000_0000, 1'b0, 48'h0},
    '{spmv_pkg::KIND_END_ROW, 10'd1023, 32'hFFFF_FFFF, 1'b1, spmv_pkg::SUM_MIN},
    '{spmv_pkg::KIND_NONZERO, 10'd1,    32'hFFFF_FFFF, 1'b0, 48'h0},
    '{spmv_pkg::KIND_END_ROW, 10'd0,    32'h0000_0000, 1'b1, 48'hFFFF_FFFF_FFFF},
    '{spmv_pkg::KIND_NONZERO, 10'd1,    32'h0003_8000, 1'b0, 48'h0},
    '{spmv_pkg::KIND_END_ROW, 10'd0,    32'h0000_0000, 1'b1, 48'h0000_0003_8000},
    '{spmv_pkg::KIND_LOAD,    10'd1,    32'hFFFF_8000, 1'b0, 48'h0},
    '{spmv_pkg::KIND_NONZERO, 10'd1,    32'h0000_0001, 1'b0, 48'h0},
    '{spmv_pkg::KIND_END_ROW, 10'd0,    32'h0000_0000, 1'b1, 48'hFFFF_FFFF_FFFF}
  };

  // Subarray count, copy, read and write latency for each random phase.
  localparam int unsigned CFG_PLAN [NUM_PHASES][4] = '{
    '{4, 15, 0, 15}, '{0, 0, 15, 0}, '{64, 1, 2, 3},
    '{127, 15, 15, 15}, '{3, 0, 1, 7}, '{2, 7, 0, 1},
    '{65, 3, 5, 0}, '{1, 15, 15, 15}, '{5, 2, 9, 4}
  };

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              cfg_we_i = 1'b0;
  logic [spmv_pkg::CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [spmv_pkg::CFG_DATA_W-1:0]   cfg_data_i = '0;
  logic                              in_valid_i = 1'b0;
  logic                              in_stall_o;
  logic [spmv_pkg::KIND_W-1:0]       kind_i = '0;
  logic [spmv_pkg::IDX_W-1:0]        index_i = '0;
  logic signed [spmv_pkg::VAL_W-1:0] value_i = '0;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  logic [spmv_pkg::ROW_W-1:0]        row_number_o;
  logic signed [spmv_pkg::SUM_W-1:0] row_sum_o;
  logic [spmv_pkg::CYC_W-1:0]        cycle_count_o;
  logic [spmv_pkg::CNT_W-1:0]        transfer_count_o;
  logic [spmv_pkg::CNT_W-1:0]        psum_xfer_count_o;

  logic [spmv_pkg::VAL_W-1:0]        x_copy [XD];
  bit                                x_written [XD];
  int unsigned                       written_cols [$];
  logic signed [spmv_pkg::SUM_W-1:0] acc_sum = '0;
  logic [spmv_pkg::ROW_W-1:0]        row_ctr = '0;
  int unsigned                       row_sub = 0;
  logic                              row_nonempty = 1'b0;
  logic [spmv_pkg::CYC_W-1:0]        cyc_total = '0;
  logic [spmv_pkg::CNT_W-1:0]        xfer_total = '0;
  logic [spmv_pkg::CNT_W-1:0]        psum_total = '0;
  logic [spmv_pkg::NUM_SUB_W-1:0]    cfg_num_sub = 1;
  logic [spmv_pkg::LAT_W-1:0]        cfg_copy_lat = 1;
  logic [spmv_pkg::LAT_W-1:0]        cfg_read_lat = 1;
  logic [spmv_pkg::LAT_W-1:0]        cfg_write_lat = 1;

  row_result_t                       pending_rows [$];
  int unsigned                       words_sent = 0;
  int unsigned                       fail_count = 0;
  int unsigned                       send_idle_pct = 8;
  int unsigned                       recv_stall_pct = 63;
  int unsigned                       quiet_cycles = 0;

  spmv_row_accumulator_with_transfer_cost_top #(.X_DEPTH(XD)) u_top (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [spmv_pkg::CYC_W-1:0] add_cyc(logic [spmv_pkg::CYC_W-1:0] total,
                                                         int unsigned c);
    logic [spmv_pkg::CYC_W:0] t;
    t = {1'b0, total} + c;
    return t[spmv_pkg::CYC_W] ? {spmv_pkg::CYC_W{1'b1}} : t[spmv_pkg::CYC_W-1:0];
  endfunction

  function automatic logic [spmv_pkg::CNT_W-1:0] bump(logic [spmv_pkg::CNT_W-1:0] c);
    return (c == {spmv_pkg::CNT_W{1'b1}}) ? c : c + 1'b1;
  endfunction

  function automatic logic [spmv_pkg::VAL_W-1:0] rand_value();
    logic [spmv_pkg::VAL_W-1:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2, 3, 4, 5: return {{14{r[17]}}, r[17:0]};
      default: return r;
    endcase
  endfunction

  task automatic predict_word(input logic [spmv_pkg::KIND_W-1:0] kind,
                              input logic [spmv_pkg::IDX_W-1:0] idx,
                              input logic [spmv_pkg::VAL_W-1:0] val);
    int unsigned n;
    longint prod;
    longint s;
    row_result_t r;
    n = (cfg_num_sub == 0) ? 1 :
        (cfg_num_sub > spmv_pkg::MAX_SUBARRAYS) ? spmv_pkg::MAX_SUBARRAYS : cfg_num_sub;
    if (row_sub >= n) row_sub = 0;
    case (kind)
      spmv_pkg::KIND_LOAD: begin
        x_copy[idx] = val;
        if (!x_written[idx]) begin
          x_written[idx] = 1'b1;
          written_cols = {written_cols, 32'(idx)};
        end
      end
      spmv_pkg::KIND_NONZERO: begin
        if (idx % n != row_sub) begin
          xfer_total = bump(xfer_total);
          cyc_total = add_cyc(cyc_total, cfg_copy_lat);
        end else begin
          cyc_total = add_cyc(cyc_total, cfg_read_lat);
        end
        cyc_total = add_cyc(cyc_total, 1);
        prod = (longint'(signed'(val)) * longint'(signed'(x_copy[idx]))) >>> spmv_pkg::FRAC_W;
        s = longint'(acc_sum) + prod;
        if (s > SUM_HI) s = SUM_HI;
        if (s < SUM_LO) s = SUM_LO;
        acc_sum = s[spmv_pkg::SUM_W-1:0];
        row_nonempty = 1'b1;
      end
      spmv_pkg::KIND_END_ROW: begin
        cyc_total = add_cyc(cyc_total, cfg_write_lat);
        if (row_ctr % spmv_pkg::PSUM_EVERY == 0 && row_nonempty && n > 1) begin
          psum_total = bump(psum_total);
          xfer_total = bump(xfer_total);
          cyc_total = add_cyc(cyc_total, cfg_copy_lat);
        end
        r.row_number = row_ctr;
        r.row_sum = acc_sum;
        r.cycle_count = cyc_total;
        r.transfer_count = xfer_total;
        r.psum_xfer_count = psum_total;
        pending_rows = {pending_rows, r};
        row_ctr = row_ctr + 1'b1;
        row_sub = (row_sub + 1 >= n) ? 0 : row_sub + 1;
        acc_sum = '0;
        row_nonempty = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic send_word(input logic [spmv_pkg::KIND_W-1:0] kind,
                           input logic [spmv_pkg::IDX_W-1:0] idx,
                           input logic [spmv_pkg::VAL_W-1:0] val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    index_i <= idx;
    value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
    predict_word(kind, idx, val);
    if (kind != KIND_UNUSED) words_sent++;
  endtask

  task automatic write_cfg(input logic [spmv_pkg::CFG_IDX_W-1:0] idx, input int unsigned data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data[spmv_pkg::CFG_DATA_W-1:0];
    @(posedge clk_i);
    case (idx)
      spmv_pkg::CFG_NUM_SUB:   cfg_num_sub = data[spmv_pkg::NUM_SUB_W-1:0];
      spmv_pkg::CFG_COPY_LAT:  cfg_copy_lat = data[spmv_pkg::LAT_W-1:0];
      spmv_pkg::CFG_READ_LAT:  cfg_read_lat = data[spmv_pkg::LAT_W-1:0];
      spmv_pkg::CFG_WRITE_LAT: cfg_write_lat = data[spmv_pkg::LAT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (CFG_SETTLE) @(posedge clk_i);
  endtask

  task automatic send_random_row();
    int unsigned nnz;
    int unsigned r;
    logic [spmv_pkg::IDX_W-1:0] col;
    nnz = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
    for (int unsigned i = 0; i < nnz; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) send_word(spmv_pkg::KIND_LOAD, spmv_pkg::IDX_W'($urandom), rand_value());
      else if (r < 11) send_word(KIND_UNUSED, spmv_pkg::IDX_W'($urandom), $urandom);
      col = written_cols[$urandom_range(0, written_cols.size() - 1)];
      send_word(spmv_pkg::KIND_NONZERO, col, rand_value());
    end
    send_word(spmv_pkg::KIND_END_ROW, spmv_pkg::IDX_W'($urandom), $urandom);
  endtask

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    row_result_t exp_row;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_rows.size() == 0) begin
        $error("row result with none expected: row_number %0d", row_number_o);
        fail_count++;
      end else begin
        exp_row = pending_rows.pop_front();
        check_field("row_number", exp_row.row_number, row_number_o);
        check_field("row_sum", exp_row.row_sum, row_sum_o);
        check_field("cycle_count", exp_row.cycle_count, cycle_count_o);
        check_field("transfer_count", exp_row.transfer_count, transfer_count_o);
        check_field("psum_xfer_count", exp_row.psum_xfer_count, psum_xfer_count_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned target;
    row_result_t typed_row;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 20; i++) begin
      send_word(DIRECTED[i].kind, DIRECTED[i].index, DIRECTED[i].value);
      if (DIRECTED[i].sum_known) begin
        typed_row = pending_rows.pop_back();
        typed_row.row_sum = DIRECTED[i].sum;
        pending_rows = {pending_rows, typed_row};
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      if (p < 3) begin
        send_idle_pct = 8;
        recv_stall_pct = 63;
      end else if (p < 6) begin
        send_idle_pct = 63;
        recv_stall_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      write_cfg(spmv_pkg::CFG_NUM_SUB, CFG_PLAN[p][0]);
      write_cfg(spmv_pkg::CFG_COPY_LAT,
                CFG_PLAN[p][1] | ($urandom_range(0, 7) << spmv_pkg::LAT_W));
      write_cfg(spmv_pkg::CFG_READ_LAT,
                CFG_PLAN[p][2] | ($urandom_range(0, 7) << spmv_pkg::LAT_W));
      write_cfg(spmv_pkg::CFG_WRITE_LAT,
                CFG_PLAN[p][3] | ($urandom_range(0, 7) << spmv_pkg::LAT_W));
      cfg_we_i <= 1'b0;
      repeat (24) send_word(spmv_pkg::KIND_LOAD, spmv_pkg::IDX_W'($urandom), rand_value());
      target = words_sent + RANDOM_WORDS / NUM_PHASES;
      while (words_sent < target) send_random_row();
      if ($urandom_range(0, 1) == 1) begin
        repeat ($urandom_range(1, 3)) begin
          send_word(spmv_pkg::KIND_NONZERO,
                    written_cols[$urandom_range(0, written_cols.size() - 1)], rand_value());
        end
      end
    end

    send_word(spmv_pkg::KIND_END_ROW, spmv_pkg::IDX_W'($urandom), $urandom);
    wait_drained();

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
